### rtl/bpa_pkg.sv
// bpa_pkg: shared widths, codes and types of the buddy page allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 32;
    localparam int ORDER_W    = 4;
    localparam int PAGE_SHIFT = 12;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_BLOCK  = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/bpa_req_if.sv
// bpa_req_if: request channel (valid/ready) of the buddy page allocator
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [bpa_pkg::SIZE_W-1:0]   req_size;
    logic [bpa_pkg::ADDR_W-1:0]   free_address;

    modport source (output valid, output req_type, output req_size, output free_address,
                    input ready);
    modport sink   (input valid, input req_type, input req_size, input free_address,
                    output ready);
endinterface

`default_nettype wire

### rtl/bpa_rsp_if.sv
// bpa_rsp_if: result channel (valid/ready) of the buddy page allocator
// depends on bpa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::ADDR_W-1:0]    block_address;
    logic [bpa_pkg::ORDER_W-1:0]   granted_order;
    logic [1:0]                    status;

    modport source (output valid, output block_address, output granted_order,
                    output status, input ready);
    modport sink   (input valid, input block_address, input granted_order,
                    input status, output ready);
endinterface

`default_nettype wire

### rtl/bpa_page_mem.sv
// bpa_page_mem: page table memory, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bpa_page_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/bpa_ctrl.sv
// bpa_ctrl: sequencer for allocate, split, free and merge over the page table
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl #(
    parameter int MAX_ORDER  = 6,
    parameter int PAGE_COUNT = 4096,
    localparam int PW = $clog2(PAGE_COUNT),
    localparam int LW = PW + 1,
    localparam int DW = bpa_pkg::ORDER_W + 1 + 2 * LW
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [bpa_pkg::ADDR_W-1:0]  i_base_address,
    bpa_req_if.sink                          i_req,
    bpa_rsp_if.source                        o_rsp,
    output logic                             o_mem_we,
    output logic      [PW-1:0]               o_mem_waddr,
    output logic      [DW-1:0]               o_mem_wdata,
    output logic      [PW-1:0]               o_mem_raddr,
    input  wire logic [DW-1:0]               i_mem_rdata
);

    localparam int OW      = bpa_pkg::ORDER_W;
    localparam int KW      = $clog2(MAX_ORDER + 1);
    localparam int SPAN    = 1 << MAX_ORDER;
    localparam int NB      = PAGE_COUNT / SPAN;
    localparam int MANAGED = NB * SPAN;
    localparam int HEAD0   = (NB > 0) ? MANAGED - SPAN : PAGE_COUNT;
    localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);
    localparam logic FLD_PREV = 1'b0;
    localparam logic FLD_NEXT = 1'b1;

    typedef struct packed {
        logic [OW-1:0] order;
        logic          used;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } t_page;

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_SCAN   = 15'b000000000000100,
        S_ARD    = 15'b000000000001000,
        S_AREM   = 15'b000000000010000,
        S_SPLIT  = 15'b000000000100000,
        S_FREE0  = 15'b000000001000000,
        S_FCHK   = 15'b000000010000000,
        S_MCHK   = 15'b000000100000000,
        S_MBUD   = 15'b000001000000000,
        S_MN     = 15'b000010000000000,
        S_FPUSH  = 15'b000100000000000,
        S_RMW_RD = 15'b001000000000000,
        S_RMW_WR = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state                        r_state, n_state;
    t_state                        r_ret, n_ret;
    logic [PW-1:0]                 r_cnt, n_cnt;
    logic [LW-1:0]                 r_first [MAX_ORDER+1];
    logic [LW-1:0]                 n_first [MAX_ORDER+1];
    logic [PW-1:0]                 r_p, n_p;
    logic [OW-1:0]                 r_k, n_k;
    logic [OW-1:0]                 r_want, n_want;
    logic [PW-1:0]                 r_x, n_x;
    logic [LW-1:0]                 r_val, n_val;
    logic                          r_fld, n_fld;
    logic [LW-1:0]                 r_n, n_n;
    logic [LW-1:0]                 r_pv, n_pv;
    logic [bpa_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [OW-1:0]                 r_ord, n_ord;
    bpa_pkg::t_status              r_st, n_st;

    t_page                         w_rd;
    t_page                         w_wd;
    t_page                         w_init;
    logic [PW-1:0]                 w_bud;
    logic                          w_bud_ok;
    logic [OW-1:0]                 w_lo;
    logic [KW-1:0]                 w_ki;
    logic [KW-1:0]                 w_loi;
    logic [PW-1:0]                 w_sbud;
    logic [LW-1:0]                 w_head;
    logic [LW-1:0]                 w_lo_head;
    logic [OW-1:0]                 w_want;
    logic                          w_fits;
    logic [bpa_pkg::ADDR_W-1:0]    w_diff;
    logic                          w_idx_ok;

    assign w_rd      = t_page'(i_mem_rdata);
    assign w_bud     = r_p ^ (PW'(1) << r_k);
    assign w_bud_ok  = {1'b0, w_bud} < NIL;
    assign w_lo      = r_k - OW'(1);
    assign w_ki      = r_k[KW-1:0];
    assign w_loi     = w_lo[KW-1:0];
    assign w_sbud    = r_p ^ (PW'(1) << w_lo);
    assign w_head    = r_first[w_ki];
    assign w_lo_head = r_first[w_loi];
    assign w_diff    = i_req.free_address - i_base_address;
    assign w_idx_ok  = (w_diff >> bpa_pkg::PAGE_SHIFT) < bpa_pkg::ADDR_W'(PAGE_COUNT);

    // smallest order that holds the size
    always_comb begin
        w_want = '0;
        w_fits = 1'b0;
        for (int t = MAX_ORDER; t >= 0; t--) begin
            if ({1'b0, i_req.req_size} <= (33'h1000 << t)) begin
                w_want = OW'(t);
                w_fits = 1'b1;
            end
        end
    end

    // reset contents of one page: whole max-order blocks chained descending
    always_comb begin
        int  ci;
        logic start;
        ci    = int'(r_cnt);
        start = ((ci & (SPAN - 1)) == 0) && (ci < MANAGED);
        w_init.order = start ? OW'(MAX_ORDER) : '0;
        w_init.used  = 1'b0;
        w_init.nxt   = (start && ci >= SPAN) ? LW'(ci - SPAN) : NIL;
        w_init.prv   = (start && ci + SPAN < MANAGED) ? LW'(ci + SPAN) : NIL;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_p     = r_p;
        n_k     = r_k;
        n_want  = r_want;
        n_x     = r_x;
        n_val   = r_val;
        n_fld   = r_fld;
        n_n     = r_n;
        n_pv    = r_pv;
        n_addr  = r_addr;
        n_ord   = r_ord;
        n_st    = r_st;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_raddr = '0;
        w_wd        = w_rd;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt;
                w_wd        = w_init;
                n_cnt       = r_cnt + PW'(1);
                if (r_cnt == PW'(PAGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_addr = '0;
                    n_ord  = '0;
                    if (i_req.req_type == bpa_pkg::REQ_ALLOC) begin
                        if (!w_fits) begin
                            n_st    = bpa_pkg::ST_TOO_LARGE;
                            n_state = S_DONE;
                        end else begin
                            n_want  = w_want;
                            n_k     = w_want;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (!w_idx_ok) begin
                            n_st    = bpa_pkg::ST_NO_BLOCK;
                            n_state = S_DONE;
                        end else begin
                            n_p     = w_diff[bpa_pkg::PAGE_SHIFT +: PW];
                            n_state = S_FREE0;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_head != NIL) begin
                    n_p     = w_head[PW-1:0];
                    n_state = S_ARD;
                end else if (r_k == OW'(MAX_ORDER)) begin
                    n_st    = bpa_pkg::ST_NO_BLOCK;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + OW'(1);
                end
            end
            S_ARD: begin
                o_mem_raddr = r_p;
                n_state     = S_AREM;
            end
            S_AREM: begin
                n_first[w_ki] = w_rd.nxt;
                n_state       = S_SPLIT;
                if (w_rd.nxt != NIL) begin
                    n_x     = w_rd.nxt[PW-1:0];
                    n_val   = NIL;
                    n_fld   = FLD_PREV;
                    n_ret   = S_SPLIT;
                    n_state = S_RMW_RD;
                end
            end
            S_SPLIT: begin
                o_mem_we = 1'b1;
                if (r_k == r_want) begin
                    o_mem_waddr = r_p;
                    w_wd        = '{order: r_want, used: 1'b1, nxt: NIL, prv: NIL};
                    n_addr      = i_base_address
                                + (bpa_pkg::ADDR_W'(r_p) << bpa_pkg::PAGE_SHIFT);
                    n_ord       = r_want;
                    n_st        = bpa_pkg::ST_OK;
                    n_state     = S_DONE;
                end else begin
                    // upper buddy goes onto the list one order down
                    o_mem_waddr    = w_sbud;
                    w_wd           = '{order: w_lo, used: 1'b0, nxt: w_lo_head, prv: NIL};
                    n_first[w_loi] = {1'b0, w_sbud};
                    n_k            = w_lo;
                    if (w_lo_head != NIL) begin
                        n_x     = w_lo_head[PW-1:0];
                        n_val   = {1'b0, w_sbud};
                        n_fld   = FLD_PREV;
                        n_ret   = S_SPLIT;
                        n_state = S_RMW_RD;
                    end
                end
            end
            S_FREE0: begin
                o_mem_raddr = r_p;
                n_state     = S_FCHK;
            end
            S_FCHK: begin
                if (!w_rd.used) begin
                    n_st    = bpa_pkg::ST_NO_BLOCK;
                    n_state = S_DONE;
                end else begin
                    n_k     = w_rd.order;
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                if (r_k >= OW'(MAX_ORDER) || !w_bud_ok) begin
                    n_state = S_FPUSH;
                end else begin
                    o_mem_raddr = w_bud;
                    n_state     = S_MBUD;
                end
            end
            S_MBUD: begin
                if (w_rd.order != r_k || w_rd.used) begin
                    n_state = S_FPUSH;
                end else begin
                    // the upper half of the merged pair keeps only its order
                    o_mem_we    = 1'b1;
                    o_mem_waddr = (w_bud > r_p) ? w_bud : r_p;
                    w_wd        = '{order: r_k + OW'(1), used: 1'b0, nxt: NIL, prv: NIL};
                    n_p         = (w_bud < r_p) ? w_bud : r_p;
                    n_k         = r_k + OW'(1);
                    n_n         = w_rd.nxt;
                    n_pv        = w_rd.prv;
                    n_state     = S_MN;
                    if (w_rd.prv != NIL) begin
                        n_x     = w_rd.prv[PW-1:0];
                        n_val   = w_rd.nxt;
                        n_fld   = FLD_NEXT;
                        n_ret   = S_MN;
                        n_state = S_RMW_RD;
                    end else begin
                        n_first[w_ki] = w_rd.nxt;
                    end
                end
            end
            S_MN: begin
                n_state = S_MCHK;
                if (r_n != NIL) begin
                    n_x     = r_n[PW-1:0];
                    n_val   = r_pv;
                    n_fld   = FLD_PREV;
                    n_ret   = S_MCHK;
                    n_state = S_RMW_RD;
                end
            end
            S_FPUSH: begin
                o_mem_we      = 1'b1;
                o_mem_waddr   = r_p;
                w_wd          = '{order: r_k, used: 1'b0, nxt: w_head, prv: NIL};
                n_first[w_ki] = {1'b0, r_p};
                n_addr        = '0;
                n_ord         = r_k;
                n_st          = bpa_pkg::ST_OK;
                n_state       = S_DONE;
                if (w_head != NIL) begin
                    n_x     = w_head[PW-1:0];
                    n_val   = {1'b0, r_p};
                    n_fld   = FLD_PREV;
                    n_ret   = S_DONE;
                    n_state = S_RMW_RD;
                end
            end
            S_RMW_RD: begin
                o_mem_raddr = r_x;
                n_state     = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_x;
                if (r_fld == FLD_NEXT) begin
                    w_wd.nxt = r_val;
                end else begin
                    w_wd.prv = r_val;
                end
                n_state = r_ret;
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_mem_wdata = w_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            for (int i = 0; i <= MAX_ORDER; i++) begin
                r_first[i] <= (i == MAX_ORDER) ? LW'(HEAD0) : NIL;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_k    <= n_k;
        r_want <= n_want;
        r_x    <= n_x;
        r_val  <= n_val;
        r_fld  <= n_fld;
        r_n    <= n_n;
        r_pv   <= n_pv;
        r_addr <= n_addr;
        r_ord  <= n_ord;
        r_st   <= n_st;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_DONE);
    assign o_rsp.block_address = r_addr;
    assign o_rsp.granted_order = r_ord;
    assign o_rsp.status        = r_st;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request taken while a result is pending");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != bpa_pkg::ST_OK)
        |-> (o_rsp.block_address == '0 && o_rsp.granted_order == '0))
        else $error("error result carries an address or order");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> ({1'b0, o_mem_waddr} < NIL))
        else $error("page table write outside the region");

    a_clear_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("ready during the clearing pass");
`endif

endmodule

`default_nettype wire

### rtl/buddy_page_allocator_core.sv
// buddy_page_allocator_core: top level with configuration port, sequencer and page table
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl, bpa_page_mem
`timescale 1ns / 1ps
`default_nettype none

// Buddy allocator over PAGE_COUNT pages of 4 KiB, block orders 0 to MAX_ORDER. One request
// is handled at a time; ready is low from acceptance until its result is taken. After
// reset a clearing pass writes every entry of the page table with ready low. All work
// goes through one page table memory with one access per cycle: an allocate scans the
// orders from the wanted one upward, removes the found block, splits it down and relinks
// list neighbors; a free reads the page, merges with free buddies while unlinking each
// buddy, and links the pushed block. An oversized request or an address outside the
// region answers straight from idle, a free of a page not in use after reading its
// entry, and an allocate with no free block after scanning the orders up to MAX_ORDER.
module buddy_page_allocator_core #(
    parameter int MAX_ORDER  = 6,
    parameter int PAGE_COUNT = 4096
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready,
    bpa_req_if.sink           i_req,
    bpa_rsp_if.source         o_rsp
);

    localparam int PW = $clog2(PAGE_COUNT);
    localparam int LW = PW + 1;
    localparam int DW = bpa_pkg::ORDER_W + 1 + 2 * LW;

    logic [bpa_pkg::ADDR_W-1:0] r_base;
    logic                       w_mem_we;
    logic [PW-1:0]              w_mem_waddr;
    logic [DW-1:0]              w_mem_wdata;
    logic [PW-1:0]              w_mem_raddr;
    logic [DW-1:0]              w_mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && !paddr[3]) begin
            r_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? '0 : r_base;

    bpa_ctrl #(
        .MAX_ORDER  (MAX_ORDER),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_address (r_base),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata)
    );

    bpa_page_mem #(
        .DEPTH (PAGE_COUNT),
        .AW    (PW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire

### dv/buddy_page_allocator_core_test.sv
// buddy_page_allocator_core_test: self-checking testbench of the buddy page allocator core
// tracks free lists, page orders and used marks on its own and checks every result item
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if and buddy_page_allocator_core
`timescale 1ns / 1ps

module buddy_page_allocator_core_test;

    localparam int PAGES     = 4096;
    localparam int TOP_ORDER = 6;
    localparam logic [12:0] NIL_PAGE = 13'(PAGES);
    localparam logic [3:0] REG_BASE_ADDRESS = 4'h0;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [bpa_pkg::ADDR_W-1:0]  block_address;
        logic [bpa_pkg::ORDER_W-1:0] granted_order;
        bpa_pkg::t_status            status;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // allocator state as seen from outside
    logic [63:0]        base_addr;
    logic [3:0]         pg_order [PAGES];
    bit                 pg_used  [PAGES];
    logic [12:0]        pg_next  [PAGES];
    logic [12:0]        pg_prev  [PAGES];
    logic [12:0]        free_head [TOP_ORDER+1];
    int                 live_pages [$];
    t_grant             pending_grants [$];

    int  errors;
    int  sent_items;
    int  checked_items;
    int  grants_ok;
    int  refusals;
    int  idle_cycles;
    bit  quiet;
    int  rsp_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("error: %s got %h expected %h (item %0d)", what, got, exp, checked_items);
    endtask

    task automatic push_free(input int ord, input logic [12:0] p);
        logic [12:0] h;
        h = free_head[ord];
        pg_next[p] = h;
        pg_prev[p] = NIL_PAGE;
        if (h != NIL_PAGE) pg_prev[h] = p;
        free_head[ord] = p;
    endtask

    task automatic unlink_free(input int ord, input logic [12:0] p);
        logic [12:0] n, v;
        n = pg_next[p];
        v = pg_prev[p];
        if (v != NIL_PAGE) pg_next[v] = n;
        else free_head[ord] = n;
        if (n != NIL_PAGE) pg_prev[n] = v;
        pg_next[p] = NIL_PAGE;
        pg_prev[p] = NIL_PAGE;
    endtask

    task automatic reset_allocator();
        base_addr = '0;
        for (int i = 0; i < PAGES; i++) begin
            pg_order[i] = '0;
            pg_used[i]  = 1'b0;
            pg_next[i]  = NIL_PAGE;
            pg_prev[i]  = NIL_PAGE;
        end
        for (int i = 0; i <= TOP_ORDER; i++) free_head[i] = NIL_PAGE;
        for (int i = 0; i + (1 << TOP_ORDER) <= PAGES; i += (1 << TOP_ORDER)) begin
            pg_order[i] = 4'(TOP_ORDER);
            push_free(TOP_ORDER, 13'(i));
        end
    endtask

    task automatic serve_request(input logic kind, input logic [31:0] size,
                                 input logic [63:0] addr, output t_grant g);
        int want, t, j, k;
        bit fits;
        logic [12:0] p, b;
        logic [63:0] idx;
        g.block_address = '0;
        g.granted_order = '0;
        g.status = bpa_pkg::ST_OK;
        if (kind == bpa_pkg::REQ_ALLOC) begin
            fits = 1'b0;
            want = 0;
            for (t = 0; t <= TOP_ORDER; t++) begin
                if (!fits && {32'd0, size} <= (64'h1000 << t)) begin
                    want = t;
                    fits = 1'b1;
                end
            end
            if (!fits) begin
                g.status = bpa_pkg::ST_TOO_LARGE;
            end else begin
                t = want;
                while (t <= TOP_ORDER && free_head[t] == NIL_PAGE) t++;
                if (t > TOP_ORDER) begin
                    g.status = bpa_pkg::ST_NO_BLOCK;
                end else begin
                    p = free_head[t];
                    unlink_free(t, p);
                    pg_order[p] = 4'(t);
                    for (j = t; j > want; j--) begin
                        b = p ^ 13'(1 << (j - 1));
                        pg_order[p] = 4'(j - 1);
                        pg_order[b] = 4'(j - 1);
                        pg_used[b] = 1'b0;
                        push_free(j - 1, b);
                    end
                    pg_used[p] = 1'b1;
                    live_pages.push_back(int'(p));
                    g.block_address = base_addr + 64'(p) * 64'h1000;
                    g.granted_order = 4'(want);
                end
            end
        end else begin
            idx = (addr - base_addr) >> bpa_pkg::PAGE_SHIFT;
            if (idx >= 64'(PAGES) || !pg_used[idx[11:0]]) begin
                g.status = bpa_pkg::ST_NO_BLOCK;
            end else begin
                p = 13'(idx);
                pg_used[p] = 1'b0;
                for (int i = 0; i < live_pages.size(); i++)
                    if (live_pages[i] == int'(p)) begin
                        live_pages.delete(i);
                        break;
                    end
                forever begin
                    k = pg_order[p];
                    if (k >= TOP_ORDER) break;
                    b = p ^ 13'(1 << k);
                    if (pg_order[b] != 4'(k) || pg_used[b]) break;
                    unlink_free(k, b);
                    pg_order[p] = 4'(k + 1);
                    pg_order[b] = 4'(k + 1);
                    if (b < p) p = b;
                end
                g.granted_order = pg_order[p];
                push_free(pg_order[p], p);
            end
        end
        if (g.status == bpa_pkg::ST_OK && kind == bpa_pkg::REQ_ALLOC) grants_ok++;
        if (g.status != bpa_pkg::ST_OK) refusals++;
    endtask

    task automatic send_item(input logic kind, input logic [31:0] size, input logic [63:0] addr);
        t_grant g;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.req_type     = kind;
        req_ch.req_size     = size;
        req_ch.free_address = addr;
        forever begin
            @(posedge i_clk);
            if (req_ch.ready) break;
            @(negedge i_clk);
        end
        serve_request(kind, size, addr, g);
        pending_grants.push_back(g);
        sent_items++;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic alloc_bytes(input logic [31:0] size);
        send_item(bpa_pkg::REQ_ALLOC, size, {$urandom, $urandom});
    endtask

    task automatic free_at(input logic [63:0] addr);
        send_item(bpa_pkg::REQ_FREE, $urandom, addr);
    endtask

    function automatic logic [63:0] page_addr(input int p);
        return base_addr + 64'(p) * 64'h1000;
    endfunction

    task automatic wait_drained();
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [63:0] value);
        logic [63:0] rd;
        wait_drained();
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = REG_BASE_ADDRESS; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        base_addr = value;
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        if (rd !== value) report("base_address readback", rd, value);
    endtask

    task automatic free_all_live();
        int i;
        logic [63:0] a;
        live_pages.shuffle();
        while (live_pages.size() != 0) begin
            i = $urandom_range(0, live_pages.size() - 1);
            a = page_addr(live_pages[i]);
            free_at(a);
        end
    endtask

    task automatic test_size_edges();
        alloc_bytes(32'd0);
        alloc_bytes(32'd1);
        alloc_bytes(32'h1000);
        alloc_bytes(32'h1001);
        alloc_bytes(32'h2000);
        alloc_bytes(32'h40000);
        alloc_bytes(32'h40001);
        alloc_bytes(32'hFFFF_FFFF);
        free_all_live();
    endtask

    task automatic test_bad_frees();
        logic [63:0] a;
        alloc_bytes(32'h3000);
        a = page_addr(live_pages[0]);
        free_at(a + 64'h1000);
        free_at(a | 64'hFFF);
        free_at(a);
        free_at(base_addr - 64'h1000);
        free_at(page_addr(PAGES));
        free_at(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_exhaustion();
        repeat (PAGES >> TOP_ORDER) alloc_bytes(32'h40000);
        alloc_bytes(32'h40000);
        alloc_bytes(32'd1);
        free_all_live();
    endtask

    task automatic test_random(input int count);
        int r, i;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (live_pages.size() > 40) r = 60 + r % 40;
            if (r < 52) begin
                if ($urandom_range(0, 19) == 0) alloc_bytes($urandom);
                else alloc_bytes($urandom_range(0, 32'h1000 << $urandom_range(0, TOP_ORDER)));
            end else if (r < 94 && live_pages.size() != 0) begin
                i = $urandom_range(0, live_pages.size() - 1);
                free_at(page_addr(live_pages[i]) | 64'($urandom_range(0, 4095)));
            end else if (r < 97) begin
                free_at(page_addr($urandom_range(0, PAGES + 8)));
            end else begin
                free_at({$urandom, $urandom});
            end
        end
    endtask

    // result items against the oldest prediction
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
                report("unexpected result item", rsp_ch.block_address, 64'd0);
            end else begin
                g = pending_grants.pop_front();
                if (rsp_ch.block_address !== g.block_address)
                    report("block_address", rsp_ch.block_address, g.block_address);
                if (rsp_ch.granted_order !== g.granted_order)
                    report("granted_order", 64'(rsp_ch.granted_order), 64'(g.granted_order));
                if (rsp_ch.status !== g.status)
                    report("status", 64'(rsp_ch.status), 64'(g.status));
            end
            checked_items++;
        end
    end

    always @(negedge i_clk) begin
        if (rsp_hold > 0 && !quiet) begin
            rsp_ch.ready = 1'b0;
            rsp_hold--;
        end else begin
            rsp_ch.ready = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) rsp_hold = $urandom_range(1, 16);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("buddy_page_allocator_core: mismatch");
            $finish;
        end
    end

    initial begin
        errors = 0; sent_items = 0; checked_items = 0; grants_ok = 0; refusals = 0;
        idle_cycles = 0; quiet = 1'b0; rsp_hold = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.req_type = bpa_pkg::REQ_ALLOC;
        req_ch.req_size = '0; req_ch.free_address = '0;
        rsp_ch.ready = 1'b1;
        reset_allocator();
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_size_edges();
        test_bad_frees();
        write_base(64'hFFFF_FFFF_FFFF_F000);
        test_bad_frees();
        test_exhaustion();
        write_base({$urandom, $urandom});
        test_random(450);
        write_base(64'hFFFF_FFFF_FFFF_FFFF);
        test_random(350);
        write_base(64'h0);
        test_random(250);
        quiet = 1'b1;
        test_random(250);
        free_all_live();

        wait_drained();
        repeat (100) @(negedge i_clk);
        $display("sent %0d request items, checked %0d results: %0d grants, %0d refusals",
                 sent_items, checked_items, grants_ok, refusals);
        $display("covered size edges, bad frees, exhaustion and four base addresses");
        if (errors == 0 && pending_grants.size() == 0) begin
            $display("buddy_page_allocator_core: match");
        end else begin
            $display("buddy_page_allocator_core: mismatch");
        end
        $finish;
    end

endmodule
